[rtl/core/xcfr_pkg.sv]
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies; imported by every module of the block.
package xcfr_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int TDATA_W     = 56;
    localparam int TUSER_W     = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_ID       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHONE_ADDRESS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOST_ADDRESS  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TYPE_CODE = 8'd3;

    localparam logic [7:0] SYNC_ID_RST       = 8'd31;
    localparam logic [7:0] PHONE_ADDRESS_RST = 8'd0;
    localparam logic [7:0] HOST_ADDRESS_RST  = 8'd16;
    localparam logic [7:0] ACK_TYPE_CODE_RST = 8'd127;

    // frame status codes
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_GOOD_HOST = 2'd1;
    localparam logic [1:0] ST_GOOD_PHONE = 2'd2;
    localparam logic [1:0] ST_CSUM_ERR  = 2'd3;

    typedef struct packed {
        logic [7:0] sync_id;
        logic [7:0] phone_address;
        logic [7:0] host_address;
        logic [7:0] ack_type_code;
    } xcfr_cfg_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic        ack_request;
        logic [7:0]  ack_sequence;
        logic        ack_seen;
        logic        sync_error;
    } xcfr_result_t;

endpackage

[rtl/core/xcfr_cfg_regs.sv]
// Configuration register file: sync id, addresses and ack type code.
// Depends on xcfr_pkg.
module xcfr_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [xcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output xcfr_pkg::xcfr_cfg_t              cfg
);
    import xcfr_pkg::*;

    xcfr_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_id       <= SYNC_ID_RST;
            cfg_reg.phone_address <= PHONE_ADDRESS_RST;
            cfg_reg.host_address  <= HOST_ADDRESS_RST;
            cfg_reg.ack_type_code <= ACK_TYPE_CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_ID:       cfg_reg.sync_id       <= cfg_data;
                REG_PHONE_ADDRESS: cfg_reg.phone_address <= cfg_data;
                REG_HOST_ADDRESS:  cfg_reg.host_address  <= cfg_data;
                REG_ACK_TYPE_CODE: cfg_reg.ack_type_code <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/xcfr_parser.sv]
// Frame parser: phase, running XOR and header registers, one byte per cycle while in_fire is high.
// Depends on xcfr_pkg.
module xcfr_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  xcfr_pkg::xcfr_cfg_t    cfg,
    input  logic                   in_fire,
    input  logic [7:0]             rx_byte,
    output xcfr_pkg::xcfr_result_t result
);
    import xcfr_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC, PH_DEST, PH_SRC, PH_TYPE, PH_LEN1, PH_LEN2, PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [7:0]  previous_xor;
    logic        dest_is_phone_reg, dest_is_phone_next;
    logic [7:0]  type_byte_reg, type_byte_next;
    logic [15:0] length_word_reg, length_word_next;
    logic [16:0] byte_count_reg, byte_count_next;
    logic [7:0]  sequence_byte_reg, sequence_byte_next;
    logic        addr_known;

    assign addr_known = (rx_byte == cfg.phone_address) || (rx_byte == cfg.host_address);

    always_comb begin
        phase_next         = phase_reg;
        // XOR of every byte before this one; only compared at the checksum byte
        previous_xor       = running_xor_reg;
        running_xor_next   = running_xor_reg ^ rx_byte;
        dest_is_phone_next = dest_is_phone_reg;
        type_byte_next     = type_byte_reg;
        length_word_next   = length_word_reg;
        byte_count_next    = byte_count_reg;
        sequence_byte_next = sequence_byte_reg;

        result               = '0;
        result.frame_status  = ST_NONE;

        case (phase_reg)
            PH_SYNC: begin
                if (rx_byte != cfg.sync_id) begin
                    result.sync_error = 1'b1;
                end else begin
                    running_xor_next = cfg.sync_id;
                    byte_count_next  = '0;
                    phase_next       = PH_DEST;
                end
            end
            PH_DEST: begin
                if (!addr_known) begin
                    result.sync_error = 1'b1;
                    phase_next        = PH_SYNC;
                end else begin
                    dest_is_phone_next = (rx_byte == cfg.phone_address);
                    phase_next         = PH_SRC;
                end
            end
            PH_SRC: begin
                if (!addr_known) begin
                    result.sync_error = 1'b1;
                    phase_next        = PH_SYNC;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_byte_next = rx_byte;
                phase_next     = PH_LEN1;
            end
            PH_LEN1: begin
                length_word_next = {rx_byte, 8'd0};
                phase_next       = PH_LEN2;
            end
            PH_LEN2: begin
                if (type_byte_reg == cfg.ack_type_code) begin
                    // ack frames carry no body and are not checked
                    result.ack_seen = 1'b1;
                    phase_next      = PH_SYNC;
                end else begin
                    length_word_next = {length_word_reg[15:8], rx_byte};
                    byte_count_next  = '0;
                    phase_next       = PH_BODY;
                end
            end
            PH_BODY: begin
                byte_count_next = byte_count_reg + 17'd1;
                if (byte_count_reg < {1'b0, length_word_reg}) begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = byte_count_reg[15:0];
                end else if (byte_count_reg == {1'b0, length_word_reg}) begin
                    sequence_byte_next = rx_byte;
                end else begin
                    result.frame_done = 1'b1;
                    if (previous_xor != rx_byte) begin
                        result.frame_status = ST_CSUM_ERR;
                    end else if (dest_is_phone_reg) begin
                        result.frame_status = ST_GOOD_PHONE;
                    end else begin
                        result.frame_status = ST_GOOD_HOST;
                        result.ack_request  = 1'b1;
                        result.ack_sequence = sequence_byte_reg;
                    end
                    phase_next = PH_SYNC;
                end
            end
            default: phase_next = PH_SYNC;
        endcase

        result.frame_type   = type_byte_next;
        result.frame_length = length_word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_SYNC;
            running_xor_reg   <= '0;
            dest_is_phone_reg <= 1'b0;
            type_byte_reg     <= '0;
            length_word_reg   <= '0;
            byte_count_reg    <= '0;
            sequence_byte_reg <= '0;
        end else if (in_fire) begin
            phase_reg         <= phase_next;
            running_xor_reg   <= running_xor_next;
            dest_is_phone_reg <= dest_is_phone_next;
            type_byte_reg     <= type_byte_next;
            length_word_reg   <= length_word_next;
            byte_count_reg    <= byte_count_next;
            sequence_byte_reg <= sequence_byte_next;
        end
    end

endmodule

[rtl/core/xcfr_out_queue.sv]
// Two-word result queue between the parser and the master port.
// Depends on xcfr_pkg.
module xcfr_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  xcfr_pkg::xcfr_result_t din,
    output logic                   can_push,
    output logic                   out_valid,
    input  logic                   out_ready,
    output xcfr_pkg::xcfr_result_t dout
);
    import xcfr_pkg::*;

    xcfr_result_t mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> can_push)
        else $error("result written into full queue");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count failed to advance");
`endif

endmodule

[rtl/core/xor_checked_frame_receiver_unit.sv]
// Top level of the XOR-checked frame receiver: ports, config, parser, result queue.
// Depends on xcfr_pkg, xcfr_cfg_regs, xcfr_parser and xcfr_out_queue.

// One received byte goes in per word on the s_ side and exactly one result word
// comes out on the m_ side for it. Throughput is one byte per clock while the queue
// has room; the parser updates its phase, byte counter and running XOR in the cycle
// a byte is taken, and its result word is written into the queue. A two-word result
// queue sits in front of the m_ port, so s_tready stays high while one result waits
// and only drops when two results are held. Configuration writes are accepted every
// cycle (cfg_ready is tied high) and should be made while no frame is in flight.
// No clearing pass after reset: the block is ready as soon as aresetn is released.
module xor_checked_frame_receiver_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input byte stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_type,
    // [47:32] frame_length, [55:48] ack_sequence
    output logic [xcfr_pkg::TDATA_W-1:0]     m_tdata,
    // [0] payload_valid, [2:1] frame_status, [3] ack_request, [4] ack_seen,
    // [5] sync_error, [7:6] zero
    output logic [xcfr_pkg::TUSER_W-1:0]     m_tuser,
    output logic                             m_tlast,   // frame_done
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [xcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import xcfr_pkg::*;

    xcfr_cfg_t    cfg;
    xcfr_result_t parse_result;
    xcfr_result_t head;
    logic         in_fire;
    logic         can_push;

    // a byte is taken whenever the queue has room
    assign s_tready = can_push;
    assign in_fire  = s_tvalid && s_tready;

    xcfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xcfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .result  (parse_result)
    );

    xcfr_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .din       (parse_result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (head)
    );

    // pack the head word onto the master port
    assign m_tdata = {head.ack_sequence, head.frame_length, head.frame_type,
                      head.payload_index, head.payload_byte};
    assign m_tuser = {2'b00, head.sync_error, head.ack_seen, head.ack_request,
                      head.frame_status, head.payload_valid};
    assign m_tlast = head.frame_done;

`ifndef NO_ASSERTIONS
    a_done_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[2:1] != ST_NONE))
        else $error("frame end reported without a status");
    a_status_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == ST_NONE))
        else $error("status reported outside a frame end");
    a_ack_only_host: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> (m_tuser[2:1] == ST_GOOD_HOST))
        else $error("acknowledge requested for a frame not good for host");
    a_kinds_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({m_tuser[0], m_tlast, m_tuser[4], m_tuser[5]}))
        else $error("result word carries more than one kind of event");
`endif

endmodule
